/* src/occupancy_grid_block_downsample_macros.svh */
// Assertion macros for the occupancy grid downsampler
`ifndef OCCUPANCY_GRID_BLOCK_DOWNSAMPLE_MACROS_SVH
`define OCCUPANCY_GRID_BLOCK_DOWNSAMPLE_MACROS_SVH

// implication checked on every edge outside reset
`define OGD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define OGD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* src/ogbd_pkg.sv */
//------------------------------------------------------------------------------
// ogbd_pkg
// Shared types and constants of the occupancy grid block downsampler.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package ogbd_pkg;
    localparam int MaxWidth  = 1024;
    localparam int MaxFactor = 16;
    localparam int MaxHeight = 1024;
    localparam int ColW      = $clog2(MaxWidth);
    localparam int RowW      = $clog2(MaxHeight);
    localparam int SubW      = $clog2(MaxFactor) + 1;
    localparam int SumW      = 17;
    localparam int CntW      = 9;

    localparam logic [1:0] REG_FACTOR = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;

    localparam logic signed [7:0] UnknownCell = -8'sd1;

    // item handed from front to back end
    typedef struct packed {
        logic signed [SumW-1:0] sum;
        logic [CntW-1:0]        count;
        logic                   unknown;
        logic                   row_end;
        logic                   last;
    } blk_t;
endpackage
`default_nettype wire

/* src/ogbd_front.sv */
//------------------------------------------------------------------------------
// ogbd_front
// Raster counters and per-column block accumulators; emits finished blocks.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module ogbd_front (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_valid,
    input  wire logic [1:0]          cfg_index,
    input  wire logic [10:0]         cfg_data,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic signed [7:0]   cell_in,
    output logic                     blk_valid,
    output ogbd_pkg::blk_t           blk,
    input  wire logic                q_space
);
    import ogbd_pkg::*;

    logic [4:0]  factor_reg;
    logic [10:0] width_reg, height_reg;
    logic [ColW-1:0] in_col_reg, out_col_reg;
    logic [RowW-1:0] in_row_reg;
    logic [SubW-1:0] sub_col_reg, sub_row_reg;

    // accumulator memory, one entry per output column
    logic [SumW+CntW:0] acc_mem [MaxWidth];

    // stage 1: read issued; stage 2: update and write back
    logic             s1_valid_reg;
    logic signed [7:0] s1_cell_reg;
    logic [ColW-1:0]  s1_idx_reg;
    logic s1_first_reg, s1_emit_reg, s1_colend_reg, s1_last_reg;
    logic [SumW+CntW:0] rd_reg;

    logic [SubW-1:0] f;
    logic [10:0] w, h;
    always_comb
    begin
        f = (factor_reg == 5'd0) ? SubW'(1)
          : (factor_reg > 5'(MaxFactor)) ? SubW'(MaxFactor) : SubW'(factor_reg);
        w = (width_reg == 11'd0) ? 11'd1
          : (width_reg > 11'(MaxWidth)) ? 11'(MaxWidth) : width_reg;
        h = (height_reg == 11'd0) ? 11'd1
          : (height_reg > 11'(MaxHeight)) ? 11'(MaxHeight) : height_reg;
    end

    logic acc;
    logic col_end, row_end, bce, bre;
    assign in_ready = q_space && !cfg_valid;
    assign acc      = in_valid && in_ready;
    assign col_end  = ({1'b0, in_col_reg} + 11'd1) >= w;
    assign row_end  = ({1'b0, in_row_reg} + 11'd1) >= h;
    assign bce      = col_end || ((sub_col_reg + SubW'(1)) >= f);
    assign bre      = row_end || ((sub_row_reg + SubW'(1)) >= f);

    // forwarding: same index written back by stage 2 as this read was issued
    logic signed [SumW-1:0] cur_sum, new_sum;
    logic [CntW-1:0] cur_cnt, new_cnt;
    logic cur_unk, new_unk;
    logic [SumW+CntW:0] prev_wr_reg;
    logic [ColW-1:0] prev_idx_reg;
    logic prev_wv_reg;
    always_comb
    begin
        {cur_sum, cur_cnt, cur_unk} = rd_reg;
        if (prev_wv_reg && prev_idx_reg == s1_idx_reg)
            {cur_sum, cur_cnt, cur_unk} = prev_wr_reg;
        if (s1_first_reg)
        begin
            new_sum = SumW'(s1_cell_reg);
            new_cnt = CntW'(1);
            new_unk = (s1_cell_reg == UnknownCell);
        end
        else
        begin
            new_sum = cur_sum + SumW'(s1_cell_reg);
            new_cnt = cur_cnt + CntW'(1);
            new_unk = cur_unk || (s1_cell_reg == UnknownCell);
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
            rd_reg <= acc_mem[out_col_reg];
        if (s1_valid_reg)
            acc_mem[s1_idx_reg] <= {new_sum, new_cnt, new_unk};
        prev_wr_reg  <= {new_sum, new_cnt, new_unk};
        prev_idx_reg <= s1_idx_reg;
        s1_cell_reg  <= cell_in;
        s1_idx_reg   <= out_col_reg;
        s1_first_reg <= (sub_col_reg == '0) && (sub_row_reg == '0);
        s1_emit_reg  <= bce && bre;
        s1_colend_reg <= col_end;
        s1_last_reg  <= col_end && row_end;
    end

    always_comb
    begin
        blk_valid   = s1_valid_reg && s1_emit_reg;
        blk.sum     = new_sum;
        blk.count   = new_cnt;
        blk.unknown = new_unk;
        blk.row_end = s1_colend_reg;
        blk.last    = s1_last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            factor_reg   <= 5'd1;
            width_reg    <= 11'd1024;
            height_reg   <= 11'd1024;
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            sub_col_reg  <= '0;
            sub_row_reg  <= '0;
            out_col_reg  <= '0;
            s1_valid_reg <= 1'b0;
            prev_wv_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= acc;
            prev_wv_reg  <= s1_valid_reg;
            if (cfg_valid && (cfg_index == REG_FACTOR || cfg_index == REG_WIDTH
                              || cfg_index == REG_HEIGHT))
            begin
                unique case (cfg_index)
                    REG_FACTOR: factor_reg <= cfg_data[4:0];
                    REG_WIDTH:  width_reg  <= cfg_data;
                    REG_HEIGHT: height_reg <= cfg_data;
                    default:    factor_reg <= factor_reg;
                endcase
                in_col_reg  <= '0;
                in_row_reg  <= '0;
                sub_col_reg <= '0;
                sub_row_reg <= '0;
                out_col_reg <= '0;
            end
            else if (acc)
            begin
                if (col_end)
                begin
                    in_col_reg  <= '0;
                    sub_col_reg <= '0;
                    out_col_reg <= '0;
                    if (row_end)
                    begin
                        in_row_reg  <= '0;
                        sub_row_reg <= '0;
                    end
                    else
                    begin
                        in_row_reg  <= in_row_reg + RowW'(1);
                        sub_row_reg <= ((sub_row_reg + SubW'(1)) >= f) ? '0
                                     : sub_row_reg + SubW'(1);
                    end
                end
                else
                begin
                    in_col_reg <= in_col_reg + ColW'(1);
                    if ((sub_col_reg + SubW'(1)) >= f)
                    begin
                        sub_col_reg <= '0;
                        out_col_reg <= out_col_reg + ColW'(1);
                    end
                    else
                        sub_col_reg <= sub_col_reg + SubW'(1);
                end
            end
        end
    end
endmodule
`default_nettype wire

/* src/ogbd_queue.sv */
//------------------------------------------------------------------------------
// ogbd_queue
// Four-entry queue of finished blocks between front and back end.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module ogbd_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           wr_en,
    input  wire ogbd_pkg::blk_t wr_data,
    output logic                rd_valid,
    output ogbd_pkg::blk_t      rd_data,
    input  wire logic           rd_en,
    output logic                space
);
    import ogbd_pkg::*;

    blk_t q_reg [4];
    logic [1:0] wp_reg, rp_reg;
    logic [2:0] cnt_reg;

    assign rd_valid = cnt_reg != 3'd0;
    assign rd_data  = q_reg[rp_reg];
    // two slots kept back for blocks already inside the front pipeline
    assign space    = cnt_reg <= 3'd2 - 3'(wr_en);

    always_ff @(posedge clk)
    begin
        if (wr_en)
            q_reg[wp_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr_en) wp_reg <= wp_reg + 2'd1;
            if (rd_en) rp_reg <= rp_reg + 2'd1;
            cnt_reg <= cnt_reg + 3'(wr_en) - 3'(rd_en);
        end
    end
endmodule
`default_nettype wire

/* src/ogbd_back.sv */
//------------------------------------------------------------------------------
// ogbd_back
// Serial signed divider producing the block average, with output register.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module ogbd_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           q_valid,
    input  wire ogbd_pkg::blk_t q_data,
    output logic                q_pop,
    output logic                m_valid,
    output logic [9:0]          m_data,
    input  wire logic           m_ready
);
    import ogbd_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_DIV, S_OUT} state_t;
    state_t state_reg;
    logic [SumW-1:0] quo_reg;
    logic [CntW:0]   rem_reg;
    logic [CntW-1:0] den_reg;
    logic [4:0]      step_reg;
    logic            neg_reg, re_reg, last_reg;
    logic [7:0]      val_reg;

    logic [CntW:0] trial;
    logic [CntW:0] shifted;
    logic [SumW-1:0] mag;
    logic [SumW-1:0] qres;
    always_comb
    begin
        shifted = {rem_reg[CntW-1:0], quo_reg[SumW-1]};
        trial   = shifted - {1'b0, den_reg};
        mag     = q_data.sum[SumW-1] ? SumW'(-q_data.sum) : q_data.sum;
        qres    = neg_reg ? SumW'(-quo_reg) : quo_reg;
    end

    assign q_pop   = (state_reg == S_IDLE) && q_valid;
    assign m_valid = state_reg == S_OUT;
    assign m_data  = {last_reg, re_reg, val_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            quo_reg <= '0; rem_reg <= '0; den_reg <= '0; step_reg <= '0;
            neg_reg <= 1'b0; re_reg <= 1'b0; last_reg <= 1'b0; val_reg <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                    if (q_valid)
                    begin
                        re_reg   <= q_data.row_end;
                        last_reg <= q_data.last;
                        if (q_data.unknown || q_data.count == '0)
                        begin
                            val_reg   <= UnknownCell;
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            quo_reg   <= mag;
                            rem_reg   <= '0;
                            den_reg   <= q_data.count;
                            neg_reg   <= q_data.sum[SumW-1];
                            step_reg  <= 5'(SumW);
                            state_reg <= S_DIV;
                        end
                    end
                S_DIV:
                    if (step_reg == 5'd0)
                    begin
                        val_reg   <= qres[7:0];
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        step_reg <= step_reg - 5'd1;
                        if (!trial[CntW])
                        begin
                            rem_reg <= trial;
                            quo_reg <= {quo_reg[SumW-2:0], 1'b1};
                        end
                        else
                        begin
                            rem_reg <= shifted;
                            quo_reg <= {quo_reg[SumW-2:0], 1'b0};
                        end
                    end
                S_OUT:
                    if (m_ready)
                        state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

/* src/occupancy_grid_block_downsample.sv */
//------------------------------------------------------------------------------
// occupancy_grid_block_downsample
// Block-average downsampler for a raster occupancy grid.
//------------------------------------------------------------------------------
// Usage: cells enter on s_axis in raster order, one signed cell in tdata per
// request. Registers (factor, width, height) are written on the cfg channel
// while nothing is in flight; any write to a listed register restarts the
// frame, and s_axis_tready is low while cfg_valid is high. Each finished
// block yields one request on m_axis: tdata carries the value, tuser marks
// the end of a downsized row and tlast the end of the downsized grid.
// The front end takes one cell per cycle while its block queue has room.
// The back end pops a block, runs it through the serial divider (17
// quotient bits, one a cycle, then a step to apply the sign) and holds the
// result in its output register; an unknown block skips the divider.
// With factor 1 every cell is a block, so sustained input is set by the
// back end, which takes a new block only after the last has been output.
// Reset clears counters and registers to factor 1, 1024 x 1024.
// A stalled receiver holds the output; the queue then fills and s_axis_tready
// drops. The accumulator memory needs no clearing pass.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module occupancy_grid_block_downsample (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [10:0] cfg_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // cell_value
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // out_value
    output logic             m_axis_tuser,   // out_row_end
    output logic             m_axis_tlast
);
    import ogbd_pkg::*;

    logic blk_valid, q_space, q_valid, q_pop;
    blk_t blk, q_data;
    logic [9:0] m_data;

    assign cfg_ready    = 1'b1;
    assign m_axis_tdata = m_data[7:0];
    assign m_axis_tuser = m_data[8];
    assign m_axis_tlast = m_data[9];

    ogbd_front u_front (
        .clk, .rst_n, .cfg_valid, .cfg_index, .cfg_data,
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .cell_in(s_axis_tdata), .blk_valid, .blk, .q_space
    );
    ogbd_queue u_queue (
        .clk, .rst_n, .wr_en(blk_valid), .wr_data(blk),
        .rd_valid(q_valid), .rd_data(q_data), .rd_en(q_pop), .space(q_space)
    );
    ogbd_back u_back (
        .clk, .rst_n, .q_valid, .q_data, .q_pop,
        .m_valid(m_axis_tvalid), .m_data, .m_ready(m_axis_tready)
    );
endmodule
`default_nettype wire

/* src/ogbd_checker.sv */
//------------------------------------------------------------------------------
// ogbd_checker
// Port-level checks of the downsampler, bound to the top level.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "occupancy_grid_block_downsample_macros.svh"
module ogbd_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       cfg_valid,
    input wire logic       s_axis_tready,
    input wire logic       m_axis_tvalid,
    input wire logic       m_axis_tready,
    input wire logic [7:0] m_axis_tdata,
    input wire logic       m_axis_tuser,
    input wire logic       m_axis_tlast
);
    logic       m_stall;
    logic [9:0] m_word;
    assign m_stall = m_axis_tvalid && !m_axis_tready;
    assign m_word  = {m_axis_tlast, m_axis_tuser, m_axis_tdata};

    `OGD_ASSERT_IMP(a_last_row, clk, rst_n, m_axis_tvalid && m_axis_tlast, m_axis_tuser)
    `OGD_ASSERT_NXT(a_hold, clk, rst_n, m_stall, m_axis_tvalid && $stable(m_word))
    `OGD_ASSERT_IMP(a_cfg_stall, clk, rst_n, cfg_valid, !s_axis_tready)
    `OGD_ASSERT_IMP(a_known, clk, rst_n, m_axis_tvalid, !$isunknown(m_word))
endmodule

bind occupancy_grid_block_downsample ogbd_checker u_ogbd_checker (
    .clk, .rst_n, .cfg_valid, .s_axis_tready, .m_axis_tvalid, .m_axis_tready,
    .m_axis_tdata, .m_axis_tuser, .m_axis_tlast
);
`default_nettype wire

/* dv/occupancy_grid_block_downsample_tb.sv */
//------------------------------------------------------------------------------
// occupancy_grid_block_downsample_tb
// Self-checking bench for the block-average grid downsampler. A scoreboard
// keeps its own copy of the block accumulators and predicts each downsized
// cell. Directed grids cover the register extremes and edge blocks; random
// grids follow under several sender and receiver idling phases.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module occupancy_grid_block_downsample_tb;
    import ogbd_pkg::*;

    localparam int  LIMIT_CYCLES = 3_000_000;
    localparam int  DRAIN_CYCLES = 40;
    localparam logic [1:0] REG_NONE = 2'd3;

    typedef struct {
        logic signed [7:0] value;
        logic              row_end;
        logic              last;
    } down_cell_t;

    class downsample_scoreboard;
        int unsigned factor, width, height;
        int unsigned col, row, sub_c, sub_r, blk_col;
        int          acc_sum [MaxWidth];
        int unsigned acc_cnt [MaxWidth];
        bit          acc_unk [MaxWidth];
        down_cell_t  downsized_q[$];
        int          errors;

        function new();
            factor = 1; width = 1024; height = 1024;
            errors = 0;
            restart();
        endfunction

        function void restart();
            col = 0; row = 0; sub_c = 0; sub_r = 0; blk_col = 0;
        endfunction

        function int unsigned clamp(int unsigned v, int unsigned hi);
            if (v == 0) return 1;
            if (v > hi) return hi;
            return v;
        endfunction

        function void write_reg(logic [1:0] idx, logic [10:0] val);
            case (idx)
                REG_FACTOR: factor = val[4:0];
                REG_WIDTH:  width  = val;
                REG_HEIGHT: height = val;
                default:    return;
            endcase
            restart();
        endfunction

        function void note_cell(logic signed [7:0] cell_val);
            int unsigned f, w, h;
            bit          c_end, r_end;
            down_cell_t  d;
            int          v;
            f = clamp(factor, MaxFactor);
            w = clamp(width, MaxWidth);
            h = clamp(height, MaxHeight);
            c_end = (col + 1 >= w);
            r_end = (row + 1 >= h);
            if (sub_c == 0 && sub_r == 0) begin
                acc_sum[blk_col] = cell_val;
                acc_cnt[blk_col] = 1;
                acc_unk[blk_col] = (cell_val == UnknownCell);
            end
            else begin
                acc_sum[blk_col] += cell_val;
                acc_cnt[blk_col] = (acc_cnt[blk_col] + 1) & 9'h1ff;
                if (cell_val == UnknownCell) acc_unk[blk_col] = 1'b1;
            end
            if ((c_end || sub_c + 1 >= f) && (r_end || sub_r + 1 >= f)) begin
                if (acc_unk[blk_col] || acc_cnt[blk_col] == 0)
                    v = UnknownCell;
                else
                    v = acc_sum[blk_col] / int'(acc_cnt[blk_col]);
                d.value   = v[7:0];
                d.row_end = c_end;
                d.last    = c_end && r_end;
                downsized_q.push_back(d);
            end
            if (c_end) begin
                col = 0; sub_c = 0; blk_col = 0;
                if (r_end) begin
                    row = 0; sub_r = 0;
                end
                else begin
                    row++;
                    sub_r = (sub_r + 1 >= f) ? 0 : sub_r + 1;
                end
            end
            else begin
                col++;
                if (sub_c + 1 >= f) begin
                    sub_c = 0; blk_col++;
                end
                else sub_c++;
            end
        endfunction

        function void check_cell(logic [7:0] got_value, logic got_row_end,
                                 logic got_last);
            down_cell_t d;
            if (downsized_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected output request: value %0d row_end %b last %b",
                             $signed(got_value), got_row_end, got_last);
                return;
            end
            d = downsized_q.pop_front();
            if (got_value !== d.value || got_row_end !== d.row_end
                || got_last !== d.last) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: exp value %0d row_end %b last %b, got %0d %b %b",
                             d.value, d.row_end, d.last, $signed(got_value),
                             got_row_end, got_last);
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [10:0] cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;    // cell_value
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;         // out_value
    logic        m_axis_tuser;         // out_row_end
    logic        m_axis_tlast;

    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          hold_cycles = 0;
    int          cycles = 0;
    downsample_scoreboard sb = new();

    occupancy_grid_block_downsample i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("occupancy_grid_block_downsample verification failed");
            $finish;
        end
    end

    // receiver: long hold-off takes priority over random stalls
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            m_axis_tready = 1'b0;
            hold_cycles--;
        end
        else
            m_axis_tready = ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_cell(m_axis_tdata, m_axis_tuser, m_axis_tlast);
    end

    task automatic send_cell(input logic [7:0] cell_val);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = cell_val;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        sb.note_cell(cell_val);
        @(negedge clk);
    endtask

    task automatic stop_cells();
        s_axis_tvalid = 1'b0;
    endtask

    task automatic wait_drain();
        stop_cells();
        while (sb.downsized_q.size() > 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [10:0] val);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.write_reg(idx, val);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_grid(input int f, input int w, input int h);
        write_reg(REG_FACTOR, f[10:0]);
        write_reg(REG_WIDTH, w[10:0]);
        write_reg(REG_HEIGHT, h[10:0]);
    endtask

    function automatic logic [7:0] rand_cell();
        int r;
        r = $urandom_range(99);
        if (r < 10) return 8'hff;
        if (r < 20) return 8'($urandom_range(255));
        return 8'($urandom_range(100));
    endfunction

    initial
    begin
        int f, w, h, n, phase, sent;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset setting: factor 1 on a 1024-wide grid
        send_cell(8'h80); send_cell(8'h7f); send_cell(8'hff);
        send_cell(8'd0);  send_cell(8'd100);
        wait_drain();

        // 3x3 grid, factor 2: partial edge blocks, unknown and negative cells
        set_grid(2, 3, 3);
        send_cell(8'd10); send_cell(8'd11); send_cell(8'hff);
        send_cell(8'd7);  send_cell(8'hfe); send_cell(8'h80);
        send_cell(8'h7f); send_cell(8'h7f); send_cell(8'd3);
        wait_drain();

        // out-of-list index is ignored, frame carries on
        set_grid(2, 2, 2);
        send_cell(8'd5);
        write_reg(REG_NONE, 11'h7ff);
        send_cell(8'd6); send_cell(8'd7); send_cell(8'd8);
        wait_drain();

        // zero and oversized registers clamp
        set_grid(0, 2047, 1);
        for (int i = 0; i < 8; i++) send_cell(rand_cell());
        wait_drain();
        write_reg(REG_FACTOR, 11'd31);   // restart mid-row
        for (int i = 0; i < 64; i++) send_cell(rand_cell());
        wait_drain();
        set_grid(16, 0, 2047);
        for (int i = 0; i < 48; i++) send_cell(rand_cell());
        wait_drain();

        // receiver holds off while cells keep coming, so the input stalls
        set_grid(1, 4, 4);
        hold_cycles = 400;
        for (int i = 0; i < 48; i++) send_cell(rand_cell());
        wait_drain();

        sent = 0;
        phase = 0;
        while (sent < 560)
        begin
            case (phase % 5)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
                3: begin send_idle_pct = 29; recv_stall_pct = 29; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            f = $urandom_range(4, 1);
            w = $urandom_range(12, 1);
            h = $urandom_range(8, 1);
            if ($urandom_range(9) == 0) f = $urandom_range(31);
            if ($urandom_range(9) == 0) write_reg(REG_NONE, 11'($urandom_range(2047)));
            set_grid(f, w, h);
            n = w * h * $urandom_range(2, 1);
            if ($urandom_range(4) == 0) n = $urandom_range(w * h);   // cut-off frame
            for (int i = 0; i < n; i++) send_cell(rand_cell());
            sent += n;
            wait_drain();
            phase++;
        end

        if (sb.errors == 0)
            $display("occupancy_grid_block_downsample verification clean");
        else
            $display("occupancy_grid_block_downsample verification failed");
        $finish;
    end
endmodule
